>>> hw/rtl/blmr_pkg.sv
// Package for the LED matrix refresh block: geometry, pin maps, gamma ROM,
// opcodes and the hold-length helper. No dependencies.
package blmr_pkg;

    localparam int PLANES   = 6;
    localparam int NUM_COLS = 20;
    localparam int NUM_ROWS = 12;
    localparam int PIXELS   = NUM_COLS * NUM_ROWS;
    localparam int ADDR_W   = $clog2(PIXELS);
    localparam int COL_W    = 5;
    localparam int ROW_W    = 4;
    localparam int PLANE_W  = 3;
    localparam int HOLD_W   = 13;
    localparam int LEVEL_W  = 6;

    localparam logic [31:0]       COLS_OFF = 32'hFFFF_0F00;
    localparam logic [HOLD_W-1:0] HOLD_MAX = 13'h1FFF;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_PUBLISH = 2'd2,
        OP_CLEAR   = 2'd3
    } t_opcode;

    // Shift register bit driving each column line and each row line
    localparam logic [4:0] COL_LINE [NUM_COLS] = '{
        5'd11, 5'd10, 5'd9,  5'd23, 5'd22, 5'd21, 5'd20, 5'd19, 5'd18, 5'd17,
        5'd31, 5'd30, 5'd29, 5'd28, 5'd27, 5'd26, 5'd25, 5'd24, 5'd8,  5'd16
    };
    localparam logic [4:0] ROW_LINE [NUM_ROWS] = '{
        5'd12, 5'd13, 5'd14, 5'd15, 5'd0, 5'd4, 5'd3, 5'd2, 5'd1, 5'd5, 5'd6, 5'd7
    };

    // Smallest 8-bit value reaching each level 1..63 (gamma 2.2)
    localparam logic [7:0] LEVEL_THRESHOLD [63] = '{
        8'd29,  8'd47,  8'd59,  8'd69,  8'd77,  8'd85,  8'd91,  8'd97,  8'd103, 8'd108,
        8'd113, 8'd118, 8'd123, 8'd127, 8'd131, 8'd135, 8'd139, 8'd143, 8'd147, 8'd150,
        8'd154, 8'd157, 8'd160, 8'd163, 8'd166, 8'd170, 8'd173, 8'd175, 8'd178, 8'd181,
        8'd184, 8'd187, 8'd189, 8'd192, 8'd194, 8'd197, 8'd199, 8'd202, 8'd204, 8'd207,
        8'd209, 8'd211, 8'd214, 8'd216, 8'd218, 8'd220, 8'd223, 8'd225, 8'd227, 8'd229,
        8'd231, 8'd233, 8'd235, 8'd237, 8'd239, 8'd241, 8'd243, 8'd245, 8'd247, 8'd249,
        8'd251, 8'd253, 8'd255
    };

    typedef logic [255:0][LEVEL_W-1:0] t_gamma_rom;

    // Elaboration-time build: level = count of thresholds not above the value
    function automatic t_gamma_rom build_gamma();
        t_gamma_rom rom;
        int         lvl;
        int         v;
        int         k;
        for (v = 0; v < 256; v++) begin
            lvl = 0;
            for (k = 0; k < 63; k++) begin
                if (v >= int'(LEVEL_THRESHOLD[k])) begin
                    lvl++;
                end
            end
            rom[v] = LEVEL_W'(lvl);
        end
        return rom;
    endfunction

    localparam t_gamma_rom GAMMA_ROM = build_gamma();

    // Hold length of a plane, saturated to the timer width
    function automatic logic [HOLD_W-1:0] hold_for(input logic [7:0]         unit_us,
                                                   input logic [PLANE_W-1:0] plane);
        logic [14:0] h;
        h = {7'b0, unit_us} << plane;
        return (h > 15'(HOLD_MAX)) ? HOLD_MAX : h[HOLD_W-1:0];
    endfunction

endpackage

>>> hw/rtl/blmr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module blmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/blmr_hold_timer.sv
// Hold timer: counts accepted ticks against the hold of the plane now lit.
// Depends on blmr_pkg.
module blmr_hold_timer
    import blmr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tick,
    input  logic [7:0]         i_unit_us,
    input  logic [PLANE_W-1:0] i_step_plane,
    output logic               o_hold_end,
    output logic [HOLD_W-1:0]  o_step_hold
);

    logic [HOLD_W-1:0]  r_elapsed;
    logic [PLANE_W-1:0] r_hold_plane;
    logic [HOLD_W-1:0]  n_elapsed;

    assign n_elapsed   = r_elapsed + 1'b1;
    assign o_hold_end  = n_elapsed >= hold_for(i_unit_us, r_hold_plane);
    assign o_step_hold = hold_for(i_unit_us, i_step_plane);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed    <= '0;
            r_hold_plane <= '0;
        end else if (i_tick) begin
            if (o_hold_end) begin
                // restart for the plane about to be shown
                r_elapsed    <= '0;
                r_hold_plane <= i_step_plane;
            end else begin
                r_elapsed <= n_elapsed;
            end
        end
    end

endmodule

>>> hw/rtl/bcm_led_matrix_refresh_top.sv
// Top level of the LED matrix refresh block: request sequencer, draft and
// shown frame RAMs, row gather. Depends on blmr_pkg, blmr_ram, blmr_hold_timer.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall) takes one request per handshake:
//    tick, pixel write, publish or clear. Output channel (o_out_valid /
//    i_out_stall) carries one shift word with its column, plane and hold.
//  - Config channel (i_cfg_valid / o_cfg_ready) loads unit_us; always ready.
//    Write it only while the block is idle.
//  - Pixel write, clear and a tick that does not end a hold do not stall.
//  - A tick that ends a hold reads the column's 12 row levels from the shown
//    RAM, one per cycle on its single read port (S_ROWS), then passes
//    S_ROW_LAST; S_OUT loads the word into the output register once it frees.
//  - Publish sweeps all 240 pixels through the gamma ROM, one per cycle,
//    then S_DRAIN. o_in_stall stays high while any multi-cycle request runs.
//  - Reset zeroes the draft frame (valid bits), the step and hold timers and
//    the published flag; unit_us returns to 3. Before the first publish every
//    word blanks all columns.
//  - If the receiver stalls, the finished word waits in the output register;
//    single-cycle requests keep flowing, and a further word waits in the
//    sequencer until the register frees.
module bcm_led_matrix_refresh_top
    import blmr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [7:0]         i_cfg_unit_us,
    output logic               o_cfg_ready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic [4:0]         i_pixel_x,
    input  logic [3:0]         i_pixel_y,
    input  logic [7:0]         i_brightness,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [31:0]        o_shift_word,
    output logic [COL_W-1:0]   o_column_index,
    output logic [PLANE_W-1:0] o_plane_index,
    output logic [HOLD_W-1:0]  o_hold_ticks
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUB,
        S_DRAIN,
        S_ROWS,
        S_ROW_LAST,
        S_OUT
    } t_state;

    t_state r_state;

    logic [7:0]         r_unit_us;
    logic               r_published;
    logic [COL_W-1:0]   r_step_col;
    logic [PLANE_W-1:0] r_step_plane;

    // word being built
    logic [COL_W-1:0]   r_col;
    logic [PLANE_W-1:0] r_plane;
    logic [HOLD_W-1:0]  r_hold;
    logic [31:0]        r_word;
    logic [ROW_W-1:0]   r_row;
    logic [ROW_W-1:0]   r_row_d;
    logic [ADDR_W-1:0]  r_row_addr;
    logic               r_lvl_pend;

    // publish sweep
    logic [ADDR_W-1:0]  r_idx;
    logic               r_pub_wr;
    logic [ADDR_W-1:0]  r_pub_addr;
    logic               r_vld_q;
    logic [PIXELS-1:0]  r_draft_vld;

    // output register
    logic               r_out_valid;
    logic [31:0]        r_out_word;
    logic [COL_W-1:0]   r_out_col;
    logic [PLANE_W-1:0] r_out_plane;
    logic [HOLD_W-1:0]  r_out_hold;

    logic               accept;
    logic               tick_acc;
    logic               in_range;
    logic               draft_we;
    logic [ADDR_W-1:0]  pix_addr;
    logic [7:0]         draft_q;
    logic [7:0]         draft_val;
    logic [LEVEL_W-1:0] shown_q;
    logic [7:0]         shown_ext;
    logic               hold_end;
    logic [HOLD_W-1:0]  step_hold;
    logic [31:0]        n_word;

    assign accept   = i_in_valid && !o_in_stall;
    assign tick_acc = accept && (t_opcode'(i_opcode) == OP_TICK);
    assign in_range = (i_pixel_x < COL_W'(NUM_COLS)) && (i_pixel_y < ROW_W'(NUM_ROWS));
    assign draft_we = accept && (t_opcode'(i_opcode) == OP_WRITE) && in_range;
    assign pix_addr = ADDR_W'(i_pixel_y) * ADDR_W'(NUM_COLS) + ADDR_W'(i_pixel_x);

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);

    // Draft frame: RAM plus per-pixel valid bits; an invalid pixel reads as zero
    blmr_ram #(
        .WIDTH (8),
        .DEPTH (PIXELS)
    ) u_draft_ram (
        .i_clk   (i_clk),
        .i_we    (draft_we),
        .i_waddr (pix_addr),
        .i_wdata (i_brightness),
        .i_raddr (r_idx),
        .o_rdata (draft_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draft_vld <= '0;
        end else if (accept && (t_opcode'(i_opcode) == OP_CLEAR)) begin
            r_draft_vld <= '0;
        end else if (draft_we) begin
            r_draft_vld[pix_addr] <= 1'b1;
        end
        // align with the registered RAM read
        r_vld_q <= r_draft_vld[r_idx];
    end

    assign draft_val = r_vld_q ? draft_q : 8'd0;

    // Shown levels: written by the publish sweep, read by the row gather
    blmr_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (PIXELS)
    ) u_shown_ram (
        .i_clk   (i_clk),
        .i_we    (r_pub_wr),
        .i_waddr (r_pub_addr),
        .i_wdata (GAMMA_ROM[draft_val]),
        .i_raddr (r_row_addr),
        .o_rdata (shown_q)
    );

    blmr_hold_timer u_hold_timer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (tick_acc),
        .i_unit_us    (r_unit_us),
        .i_step_plane (r_step_plane),
        .o_hold_end   (hold_end),
        .o_step_hold  (step_hold)
    );

    // Light the row when its level has the plane bit set; planes above the
    // level width read zero.
    assign shown_ext = {{(8 - LEVEL_W){1'b0}}, shown_q};
    always_comb begin
        n_word = r_word;
        if (r_lvl_pend && r_published && shown_ext[r_plane]) begin
            n_word = r_word | (32'd1 << ROW_LINE[r_row_d]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_unit_us    <= 8'd3;
            r_published  <= 1'b0;
            r_step_col   <= '0;
            r_step_plane <= '0;
            r_pub_wr     <= 1'b0;
            r_lvl_pend   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_unit_us <= i_cfg_unit_us;
            end
            r_pub_wr   <= 1'b0;
            r_lvl_pend <= 1'b0;
            r_word     <= n_word;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept && (t_opcode'(i_opcode) == OP_PUBLISH)) begin
                        r_idx   <= '0;
                        r_state <= S_PUB;
                    end else if (tick_acc && hold_end) begin
                        // latch the step to show, advance column/plane
                        r_col      <= r_step_col;
                        r_plane    <= r_step_plane;
                        r_hold     <= step_hold;
                        r_row      <= '0;
                        r_row_addr <= ADDR_W'(r_step_col);
                        r_word     <= r_published
                                    ? (COLS_OFF & ~(32'd1 << COL_LINE[r_step_col]))
                                    : COLS_OFF;
                        if (r_step_plane == PLANE_W'(PLANES - 1)) begin
                            r_step_plane <= '0;
                            r_step_col   <= (r_step_col == COL_W'(NUM_COLS - 1))
                                          ? '0 : r_step_col + 1'b1;
                        end else begin
                            r_step_plane <= r_step_plane + 1'b1;
                        end
                        r_state <= S_ROWS;
                    end
                end
                S_PUB: begin
                    r_pub_wr   <= 1'b1;
                    r_pub_addr <= r_idx;
                    if (r_idx == ADDR_W'(PIXELS - 1)) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DRAIN: begin
                    // last shown write lands this cycle
                    r_published <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_ROWS: begin
                    r_lvl_pend <= 1'b1;
                    r_row_d    <= r_row;
                    r_row_addr <= r_row_addr + ADDR_W'(NUM_COLS);
                    if (r_row == ROW_W'(NUM_ROWS - 1)) begin
                        r_state <= S_ROW_LAST;
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end
                S_ROW_LAST: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_word  <= r_word;
                        r_out_col   <= r_col;
                        r_out_plane <= r_plane;
                        r_out_hold  <= r_hold;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_shift_word   = r_out_word;
    assign o_column_index = r_out_col;
    assign o_plane_index  = r_out_plane;
    assign o_hold_ticks   = r_out_hold;

endmodule

>>> verif/bcm_led_matrix_refresh_top_test.sv
// Self-checking testbench for the LED matrix refresh block: directed and random
// pixel, publish, clear and tick requests, with the emitted shift words scored.
// Depends on blmr_pkg (opcodes) and bcm_led_matrix_refresh_top.
module bcm_led_matrix_refresh_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import blmr_pkg::*;

    localparam int          SCAN_COLS    = 20;
    localparam int          SCAN_ROWS    = 12;
    localparam int          SCAN_PLANES  = 6;
    localparam int          SCAN_STEPS   = SCAN_COLS * SCAN_PLANES;
    localparam int          FRAME_PIXELS = SCAN_COLS * SCAN_ROWS;
    localparam logic [31:0] BLANK_WORD   = 32'hFFFF_0F00;
    localparam logic [12:0] HOLD_CEIL    = 13'h1FFF;
    // publish sweep is the slowest request that produces no word
    localparam int          QUIET_CYCLES = 300;
    localparam int          DRAIN_LIMIT  = 100000;
    localparam int          SCENES       = 8;

    // Shift register bit of each column line and each row line
    localparam logic [4:0] COL_PIN [SCAN_COLS] = '{
        5'd11, 5'd10, 5'd9,  5'd23, 5'd22, 5'd21, 5'd20, 5'd19, 5'd18, 5'd17,
        5'd31, 5'd30, 5'd29, 5'd28, 5'd27, 5'd26, 5'd25, 5'd24, 5'd8,  5'd16
    };
    localparam logic [4:0] ROW_PIN [SCAN_ROWS] = '{
        5'd12, 5'd13, 5'd14, 5'd15, 5'd0, 5'd4, 5'd3, 5'd2, 5'd1, 5'd5, 5'd6, 5'd7
    };

    // First brightness that reaches each level 1..63 of the gamma 2.2 curve
    localparam logic [7:0] LEVEL_STEP [63] = '{
        8'd29,  8'd47,  8'd59,  8'd69,  8'd77,  8'd85,  8'd91,  8'd97,  8'd103, 8'd108,
        8'd113, 8'd118, 8'd123, 8'd127, 8'd131, 8'd135, 8'd139, 8'd143, 8'd147, 8'd150,
        8'd154, 8'd157, 8'd160, 8'd163, 8'd166, 8'd170, 8'd173, 8'd175, 8'd178, 8'd181,
        8'd184, 8'd187, 8'd189, 8'd192, 8'd194, 8'd197, 8'd199, 8'd202, 8'd204, 8'd207,
        8'd209, 8'd211, 8'd214, 8'd216, 8'd218, 8'd220, 8'd223, 8'd225, 8'd227, 8'd229,
        8'd231, 8'd233, 8'd235, 8'd237, 8'd239, 8'd241, 8'd243, 8'd245, 8'd247, 8'd249,
        8'd251, 8'd253, 8'd255
    };

    typedef struct packed {
        logic [31:0] word;
        logic [4:0]  col;
        logic [2:0]  plane;
        logic [12:0] hold;
    } t_shift_step;

    // Mirrors the refresh sequencer: draft and shown frames, step and hold
    // timers. Each tick that ends a hold queues the word it must produce.
    class shift_word_scoreboard;
        logic [7:0]  draft [FRAME_PIXELS];
        logic [5:0]  shown [FRAME_PIXELS];
        logic [5:0]  gamma [256];
        bit          published;
        int unsigned step;
        logic [2:0]  hold_plane;
        logic [12:0] elapsed;
        logic [7:0]  unit_us;
        t_shift_step pending_words [$];
        int          mismatches;

        function new();
            int lvl;
            for (int v = 0; v < 256; v++) begin
                lvl = 0;
                for (int k = 0; k < 63; k++) begin
                    if (v >= int'(LEVEL_STEP[k])) begin
                        lvl++;
                    end
                end
                gamma[v] = lvl[5:0];
            end
            foreach (draft[i]) begin
                draft[i] = 8'd0;
                shown[i] = 6'd0;
            end
            published    = 1'b0;
            step         = 0;
            hold_plane   = 3'd0;
            elapsed      = 13'd0;
            unit_us      = 8'd3;
            mismatches   = 0;
        endfunction

        // Ticks held by a plane, clipped to the 13-bit timer
        function logic [12:0] hold_len(logic [2:0] plane);
            logic [14:0] span;
            span = 15'(unit_us) << plane;
            if (span > 15'(HOLD_CEIL)) begin
                return HOLD_CEIL;
            end
            return span[12:0];
        endfunction

        function void note_request(t_opcode op, logic [4:0] x, logic [3:0] y,
                                   logic [7:0] b);
            int          col;
            int          plane;
            t_shift_step s;
            case (op)
                OP_WRITE: begin
                    if (x < SCAN_COLS && y < SCAN_ROWS) begin
                        draft[int'(y) * SCAN_COLS + int'(x)] = b;
                    end
                end
                OP_PUBLISH: begin
                    foreach (shown[i]) begin
                        shown[i] = gamma[draft[i]];
                    end
                    published = 1'b1;
                end
                OP_CLEAR: begin
                    foreach (draft[i]) begin
                        draft[i] = 8'd0;
                    end
                end
                OP_TICK: begin
                    elapsed = elapsed + 13'd1;
                    if (elapsed >= hold_len(hold_plane)) begin
                        if (step >= SCAN_STEPS) begin
                            step = 0;
                        end
                        col   = step / SCAN_PLANES;
                        plane = step % SCAN_PLANES;
                        // column line low, lit rows high; all blank until a publish
                        s.word = BLANK_WORD;
                        if (published) begin
                            s.word[COL_PIN[col]] = 1'b0;
                            for (int r = 0; r < SCAN_ROWS; r++) begin
                                if (shown[r * SCAN_COLS + col][plane]) begin
                                    s.word[ROW_PIN[r]] = 1'b1;
                                end
                            end
                        end
                        s.col   = col[4:0];
                        s.plane = plane[2:0];
                        s.hold  = hold_len(plane[2:0]);
                        pending_words.push_back(s);
                        hold_plane = plane[2:0];
                        elapsed    = 13'd0;
                        step       = (step + 1 == SCAN_STEPS) ? 0 : step + 1;
                    end
                end
            endcase
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_word(logic [31:0] w, logic [4:0] c, logic [2:0] p, logic [12:0] h);
            t_shift_step e;
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h col %0d plane %0d", w, c, p));
                return;
            end
            e = pending_words.pop_front();
            if (w !== e.word) begin
                report_mismatch($sformatf("shift_word %h, want %h (col %0d plane %0d)",
                                          w, e.word, e.col, e.plane));
            end
            if (c !== e.col) begin
                report_mismatch($sformatf("column_index %0d, want %0d", c, e.col));
            end
            if (p !== e.plane) begin
                report_mismatch($sformatf("plane_index %0d, want %0d", p, e.plane));
            end
            if (h !== e.hold) begin
                report_mismatch($sformatf("hold_ticks %0d, want %0d", h, e.hold));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic [7:0]  cfg_unit_us = 8'd0;
    logic        cfg_ready;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode      = 2'd0;
    logic [4:0]  pixel_x     = 5'd0;
    logic [3:0]  pixel_y     = 4'd0;
    logic [7:0]  brightness  = 8'd0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [31:0] shift_word;
    logic [4:0]  column_index;
    logic [2:0]  plane_index;
    logic [12:0] hold_ticks;

    bit          idle_on    = 1'b1;
    int          stall_left = 0;

    shift_word_scoreboard expected_words;

    bcm_led_matrix_refresh_top DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_unit_us  (cfg_unit_us),
        .o_cfg_ready    (cfg_ready),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_opcode       (opcode),
        .i_pixel_x      (pixel_x),
        .i_pixel_y      (pixel_y),
        .i_brightness   (brightness),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_shift_word   (shift_word),
        .o_column_index (column_index),
        .o_plane_index  (plane_index),
        .o_hold_ticks   (hold_ticks)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #10ms;
        $display("bcm_led_matrix_refresh_top regression: fail");
        $finish;
    end

    // Idle length for either side: mostly none, some short, a few long
    function int pick_gap();
        int r;
        if (!idle_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Score words as they leave, then pick the stall for the next edge
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            expected_words.check_word(shift_word, column_index, plane_index, hold_ticks);
        end
        if (stall_left > 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            out_stall  <= 1'b0;
            stall_left <= pick_gap();
        end
    end

    // Present one request and hold it until the block takes it; the
    // scoreboard learns of it at the accepting edge.
    task send_request(t_opcode op, logic [4:0] x, logic [3:0] y, logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        pixel_x    <= x;
        pixel_y    <= y;
        brightness <= b;
        do @(posedge clk); while (in_stall);
        expected_words.note_request(op, x, y, b);
    endtask

    // Tick with junk in the unused fields
    task send_tick();
        send_request(OP_TICK, 5'($urandom), 4'($urandom), 8'($urandom));
    endtask

    // Mostly on-panel writes, some off-panel, brightness often at the ends
    task write_random_pixel();
        logic [4:0] x;
        logic [3:0] y;
        logic [7:0] b;
        if ($urandom_range(0, 99) < 85) begin
            x = 5'($urandom_range(0, SCAN_COLS - 1));
            y = 4'($urandom_range(0, SCAN_ROWS - 1));
        end else begin
            x = 5'($urandom);
            y = 4'($urandom);
        end
        case ($urandom_range(0, 7))
            0:       b = 8'd0;
            1:       b = 8'd255;
            default: b = 8'($urandom);
        endcase
        send_request(OP_WRITE, x, y, b);
    endtask

    // Drop valid, drain every expected word, then let a publish sweep finish
    task go_idle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (expected_words.pending_words.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task set_unit(logic [7:0] v);
        cfg_valid   <= 1'b1;
        cfg_unit_us <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        expected_words.unit_us = v;
    endtask

    // Fill part of the draft, usually publish it, then run the scan; a little noise
    task run_scene();
        int n_writes;
        int n_ticks;
        n_writes = $urandom_range(5, 60);
        n_ticks  = $urandom_range(20, 120);
        if ($urandom_range(0, 9) == 0) begin
            send_request(OP_CLEAR, 5'($urandom), 4'($urandom), 8'($urandom));
        end
        repeat (n_writes) write_random_pixel();
        if ($urandom_range(0, 9) != 0) begin
            send_request(OP_PUBLISH, 5'($urandom), 4'($urandom), 8'($urandom));
        end
        repeat (n_ticks) begin
            if ($urandom_range(0, 19) == 0) begin
                send_request(t_opcode'($urandom_range(0, 3)), 5'($urandom),
                             4'($urandom), 8'($urandom));
            end else begin
                send_tick();
            end
        end
    endtask

    function logic [7:0] pick_unit();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) begin
            return 8'd1;
        end
        if (r < 9) begin
            return 8'($urandom_range(2, 6));
        end
        return 8'($urandom_range(7, 40));
    endfunction

    initial begin
        expected_words = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset unit: words before any publish blank every column
        repeat (7) send_tick();
        // panel corners, off-panel writes, gamma edges around level one
        send_request(OP_WRITE, 5'd0,  4'd0,  8'd255);
        send_request(OP_WRITE, 5'd19, 4'd11, 8'd255);
        send_request(OP_WRITE, 5'd20, 4'd0,  8'd255);
        send_request(OP_WRITE, 5'd31, 4'd15, 8'd255);
        send_request(OP_WRITE, 5'd0,  4'd12, 8'd200);
        send_request(OP_WRITE, 5'd1,  4'd0,  8'd28);
        send_request(OP_WRITE, 5'd2,  4'd0,  8'd29);
        send_request(OP_WRITE, 5'd3,  4'd0,  8'd254);
        send_request(OP_WRITE, 5'd0,  4'd1,  8'd170);
        send_request(OP_PUBLISH, 5'd0, 4'd0, 8'd0);
        repeat (6) send_tick();
        // clear touches the draft only; the next publish shows one pixel
        send_request(OP_CLEAR,   5'd31, 4'd15, 8'd255);
        send_request(OP_WRITE,   5'd4,  4'd4,  8'd128);
        send_request(OP_PUBLISH, 5'd0,  4'd0,  8'd0);

        // Zero unit: every tick emits, so sweep all columns and planes and wrap
        go_idle();
        set_unit(8'd0);
        repeat (80) write_random_pixel();
        send_request(OP_PUBLISH, 5'd0, 4'd0, 8'd0);
        repeat (SCAN_STEPS + 5) send_tick();

        // Random scenes, unit changed every few scenes
        go_idle();
        set_unit(8'd1);
        for (int s = 0; s < SCENES; s++) begin
            if (s > 0 && s % 3 == 0) begin
                go_idle();
                set_unit(pick_unit());
            end
            idle_on = ($urandom_range(0, 3) != 0);
            run_scene();
        end
        idle_on = 1'b1;

        // Top unit: step to a fresh plane-zero hold at unit zero, then hold it
        // at the top unit until the plane-one word with the wide hold leaves
        go_idle();
        set_unit(8'd0);
        do begin
            send_tick();
        end while (expected_words.hold_plane != 3'd0);
        go_idle();
        set_unit(8'd255);
        repeat (255) send_tick();

        go_idle();
        while (expected_words.pending_words.size() != 0) begin
            expected_words.report_mismatch("word never produced");
            void'(expected_words.pending_words.pop_front());
        end
        if (expected_words.mismatches == 0) begin
            $display("bcm_led_matrix_refresh_top regression: pass");
        end else begin
            $display("bcm_led_matrix_refresh_top regression: fail");
        end
        $finish;
    end

endmodule
